// ===== src/hcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared constants and types for the Hilbert curve converter: field widths,
// command codes, configuration reset value and the per-level orientation.
// ----------------------------------------------------------------------------
package hcc_pkg;

    // field widths
    localparam int COORD_W = 16;
    localparam int DIST_W  = 32;
    localparam int ORDER_W = 5;
    localparam int TDATA_W = 2 * COORD_W + DIST_W;

    // default largest order and reset value of the order register
    localparam int                  MAX_ORDER_DEF  = 16;
    localparam logic [ORDER_W-1:0]  GRID_ORDER_RST = 5'd16;

    // command codes carried on tuser
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // orientation of the sub-square seen at one level:
    // sw swaps the two axes, iv complements both
    typedef struct packed {
        logic sw;
        logic iv;
    } hcc_orient_t;

endpackage

// ===== src/hcc_level.sv =====
// ----------------------------------------------------------------------------
// hcc_level
// One level of the Hilbert walk. Maps a coordinate bit pair to a quadrant
// code (encode) or a quadrant code to a bit pair (decode) under the current
// orientation, and passes the updated orientation to the next lower level.
// ----------------------------------------------------------------------------
module hcc_level (
    input  logic                 active_i,   // level lies inside the grid
    input  logic                 cmd_i,
    input  logic                 x_i,
    input  logic                 y_i,
    input  logic [1:0]           q_i,
    input  hcc_pkg::hcc_orient_t orient_i,
    output hcc_pkg::hcc_orient_t orient_o,
    output logic                 x_o,
    output logic                 y_o,
    output logic [1:0]           q_o
);

    logic rx;
    logic ry;
    logic xc;
    logic yc;
    logic a;
    logic b;

    // coordinate bits in the rotated frame of this level
    assign xc = (orient_i.sw ? y_i : x_i) ^ orient_i.iv;
    assign yc = (orient_i.sw ? x_i : y_i) ^ orient_i.iv;

    // quadrant bits in the current frame, from either side
    always_comb begin
        if (cmd_i == hcc_pkg::CMD_ENCODE) begin
            rx = xc;
            ry = yc;
        end else begin
            rx = q_i[1];
            ry = q_i[0] ^ q_i[1];
        end
    end

    // decode: back to the unrotated frame
    assign a = rx ^ orient_i.iv;
    assign b = ry ^ orient_i.iv;

    // outputs, zero outside the grid
    assign q_o = active_i ? {rx, rx ^ ry} : 2'b00;
    assign x_o = active_i & (orient_i.sw ? b : a);
    assign y_o = active_i & (orient_i.sw ? a : b);

    // lower quadrants rotate when ry is clear, and flip when rx is also set
    always_comb begin
        orient_o = orient_i;
        if (active_i && !ry) begin
            orient_o.sw = ~orient_i.sw;
            orient_o.iv = orient_i.iv ^ rx;
        end
    end

endmodule

// ===== src/hcc_datapath.sv =====
// ----------------------------------------------------------------------------
// hcc_datapath
// Chain of level cells from the top level down. The orientation ripples
// through the chain; each cell produces its quadrant code and bit pair.
// Levels at or above the order pass the orientation on unchanged and give zero bits.
// ----------------------------------------------------------------------------
module hcc_datapath #(
    parameter int MAX_ORDER = hcc_pkg::MAX_ORDER_DEF
) (
    input  logic                         cmd_i,
    input  logic [hcc_pkg::ORDER_W-1:0]  order_i,
    input  logic [hcc_pkg::COORD_W-1:0]  x_i,
    input  logic [hcc_pkg::COORD_W-1:0]  y_i,
    input  logic [hcc_pkg::DIST_W-1:0]   dist_i,
    output logic [hcc_pkg::COORD_W-1:0]  x_o,
    output logic [hcc_pkg::COORD_W-1:0]  y_o,
    output logic [hcc_pkg::DIST_W-1:0]   dist_o
);

    hcc_pkg::hcc_orient_t orient [1:MAX_ORDER];
    logic                 x_lv   [MAX_ORDER];
    logic                 y_lv   [MAX_ORDER];
    logic [1:0]           q_lv   [MAX_ORDER];
    logic [hcc_pkg::COORD_W-1:0] x_raw;
    logic [hcc_pkg::COORD_W-1:0] y_raw;
    logic [hcc_pkg::DIST_W-1:0]  d_raw;

    // top level starts in the plain orientation
    assign orient[MAX_ORDER] = '0;

    // one cell per level
    for (genvar l = 0; l < MAX_ORDER; l++) begin : g_lvl
        logic       xb;
        logic       yb;
        logic [1:0] qb;
        logic       act;

        assign act = (hcc_pkg::ORDER_W'(l) < order_i);

        if (l < hcc_pkg::COORD_W) begin : g_in
            assign xb = x_i[l];
            assign yb = y_i[l];
            assign qb = dist_i[2*l+1 -: 2];
        end else begin : g_zero
            assign xb = 1'b0;
            assign yb = 1'b0;
            assign qb = 2'b00;
        end

        if (l > 0) begin : g_mid
            hcc_level u_level (
                .active_i (act),
                .cmd_i    (cmd_i),
                .x_i      (xb),
                .y_i      (yb),
                .q_i      (qb),
                .orient_i (orient[l+1]),
                .orient_o (orient[l]),
                .x_o      (x_lv[l]),
                .y_o      (y_lv[l]),
                .q_o      (q_lv[l])
            );
        end else begin : g_last
            hcc_level u_level (
                .active_i (act),
                .cmd_i    (cmd_i),
                .x_i      (xb),
                .y_i      (yb),
                .q_i      (qb),
                .orient_i (orient[l+1]),
                .orient_o (),
                .x_o      (x_lv[l]),
                .y_o      (y_lv[l]),
                .q_o      (q_lv[l])
            );
        end
    end

    // gather result bits; bits beyond the chain are zero
    for (genvar l = 0; l < hcc_pkg::COORD_W; l++) begin : g_out
        if (l < MAX_ORDER) begin : g_bit
            assign x_raw[l]         = x_lv[l];
            assign y_raw[l]         = y_lv[l];
            assign d_raw[2*l+1 -: 2] = q_lv[l];
        end else begin : g_pad
            assign x_raw[l]         = 1'b0;
            assign y_raw[l]         = 1'b0;
            assign d_raw[2*l+1 -: 2] = 2'b00;
        end
    end

    // unused result fields read as zero
    assign x_o    = (cmd_i == hcc_pkg::CMD_DECODE) ? x_raw : '0;
    assign y_o    = (cmd_i == hcc_pkg::CMD_DECODE) ? y_raw : '0;
    assign dist_o = (cmd_i == hcc_pkg::CMD_ENCODE) ? d_raw : '0;

endmodule

// ===== src/hilbert_curve_converter_unit.sv =====
// ----------------------------------------------------------------------------
// hilbert_curve_converter_unit
// Converts grid coordinates to Hilbert curve distance and back.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per conversion. s_tuser selects encode
//   (coordinates to distance) or decode (distance to coordinates).
//   m_ channel: exactly one result transaction per input transaction,
//   in order. Encode leaves x and y zero, decode leaves distance zero.
//   cfg channel: sets the grid order (log2 of the side), saturated to
//   MAX_ORDER; always ready. Write it only while no conversion is in flight.
// Timing:
//   m_tvalid rises once an accepted input has passed one input register,
//   then the chain of MAX_ORDER level cells feeding the result register.
//   Throughput is one transaction per cycle while the receiver does not
//   stall; the level chain between the two registers sets the clock period.
// Reset and stall:
//   reset empties both registers and sets the order to 16. When the
//   receiver stalls, the result holds and the input register fills; s_tready
//   then drops until m_tready returns.
// ----------------------------------------------------------------------------
module hilbert_curve_converter_unit #(
    parameter int MAX_ORDER = hcc_pkg::MAX_ORDER_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hcc_pkg::ORDER_W-1:0]  cfg_data,      // grid_order
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hcc_pkg::TDATA_W-1:0]  s_tdata,       // in_x, in_y, in_dist
    input  logic                         s_tuser,       // cmd
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [hcc_pkg::TDATA_W-1:0]  m_tdata        // out_x, out_y, out_dist
);

    localparam int CW = hcc_pkg::COORD_W;
    localparam int DW = hcc_pkg::DIST_W;

    logic [hcc_pkg::ORDER_W-1:0] grid_order_reg;
    logic [hcc_pkg::ORDER_W-1:0] order_eff;

    logic                        in_vld_reg;
    logic                        in_vld_next;
    logic                        in_cmd_reg;
    logic [CW-1:0]               in_x_reg;
    logic [CW-1:0]               in_y_reg;
    logic [DW-1:0]               in_dist_reg;

    logic                        out_vld_reg;
    logic                        out_vld_next;
    logic [CW-1:0]               out_x_reg;
    logic [CW-1:0]               out_y_reg;
    logic [DW-1:0]               out_dist_reg;

    logic                        stg_ready;
    logic [CW-1:0]               x_res;
    logic [CW-1:0]               y_res;
    logic [DW-1:0]               d_res;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_order_reg <= hcc_pkg::GRID_ORDER_RST;
        end else if (cfg_valid && cfg_ready) begin
            grid_order_reg <= cfg_data;
        end
    end

    // order saturates at the largest supported order
    assign order_eff = (grid_order_reg > hcc_pkg::ORDER_W'(MAX_ORDER))
                     ? hcc_pkg::ORDER_W'(MAX_ORDER) : grid_order_reg;

    // pipeline handshake
    assign stg_ready    = !out_vld_reg || m_tready;
    assign s_tready     = !in_vld_reg || stg_ready;
    assign in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
    assign out_vld_next = stg_ready ? in_vld_reg : out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_x_reg    <= s_tdata[CW-1:0];
            in_y_reg    <= s_tdata[2*CW-1:CW];
            in_dist_reg <= s_tdata[2*CW+DW-1:2*CW];
        end
    end

    // level chain
    hcc_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .cmd_i   (in_cmd_reg),
        .order_i (order_eff),
        .x_i     (in_x_reg),
        .y_i     (in_y_reg),
        .dist_i  (in_dist_reg),
        .x_o     (x_res),
        .y_o     (y_res),
        .dist_o  (d_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (in_vld_reg && stg_ready) begin
            out_x_reg    <= x_res;
            out_y_reg    <= y_res;
            out_dist_reg <= d_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_dist_reg, out_y_reg, out_x_reg};

endmodule

// ===== src/hcc_checker.sv =====
// ----------------------------------------------------------------------------
// hcc_checker
// Port-level checks for the Hilbert curve converter, bound to the top level.
// ----------------------------------------------------------------------------
module hcc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [hcc_pkg::TDATA_W-1:0]  m_tdata
);

    localparam int CW = hcc_pkg::COORD_W;

    // a stalled result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a result carries either coordinates or a distance, never both
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*CW-1:0] == '0) || (m_tdata[hcc_pkg::TDATA_W-1:2*CW] == '0))
        else $error("result has both coordinates and distance");

    // a ready receiver keeps the pipeline open
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while receiver ready");

    // configuration port never back-pressures
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind hilbert_curve_converter_unit hcc_checker u_hcc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

// ===== sim/hcc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hcc_scoreboard
// Watches the configuration, input and result channels of the Hilbert curve
// converter, predicts each conversion from the accepted input and the order
// in force, and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module hcc_scoreboard (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [hcc_pkg::ORDER_W-1:0] cfg_data,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [hcc_pkg::TDATA_W-1:0] s_tdata,     // in_x, in_y, in_dist
    input  logic                        s_tuser,     // cmd
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [hcc_pkg::TDATA_W-1:0] m_tdata,     // out_x, out_y, out_dist
    output int                          fail_count,
    output int                          conv_outstanding,
    output int                          conv_checked
);

    localparam int CW = hcc_pkg::COORD_W;
    localparam int DW = hcc_pkg::DIST_W;
    localparam int OW = hcc_pkg::ORDER_W;
    localparam int TW = hcc_pkg::TDATA_W;

    typedef struct packed {
        logic [DW-1:0] curve_d;
        logic [CW-1:0] y;
        logic [CW-1:0] x;
    } conv_result_t;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] y;
    } wide_pair_t;

    conv_result_t  conversion_q[$];
    logic [OW-1:0] order_reg;
    int            mismatches;

    // order register saturates at the largest supported order
    function automatic int unsigned clip_order(logic [OW-1:0] v);
        return (v > hcc_pkg::MAX_ORDER_DEF) ? hcc_pkg::MAX_ORDER_DEF : int'(v);
    endfunction

    function automatic logic [63:0] low_bits(int unsigned n);
        return (64'd1 << n) - 64'd1;
    endfunction

    // rotate or flip the sub-square for quadrant rx, ry
    function automatic wide_pair_t quad_turn(logic [63:0] s, wide_pair_t p,
                                             logic rx, logic ry);
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] b;
        wide_pair_t  r;
        r = p;
        if (!ry) begin
            m = s - 64'd1;
            a = p.x & m;
            b = p.y & m;
            if (rx) begin
                a = a ^ m;
                b = b ^ m;
            end
            r.x = b;
            r.y = a;
        end
        return r;
    endfunction

    // coordinates to curve distance, top level first
    function automatic logic [DW-1:0] xy_to_dist(int unsigned ord,
                                                 logic [CW-1:0] cx,
                                                 logic [CW-1:0] cy);
        wide_pair_t  p;
        logic [63:0] d;
        logic [63:0] s;
        logic        rx;
        logic        ry;
        p.x = {48'd0, cx} & low_bits(ord);
        p.y = {48'd0, cy} & low_bits(ord);
        d = 64'd0;
        for (int lvl = int'(ord) - 1; lvl >= 0; lvl--) begin
            s  = 64'd1 << lvl;
            rx = p.x[lvl];
            ry = p.y[lvl];
            d  = d + s * s * {62'd0, rx, rx ^ ry};
            p  = quad_turn(s, p, rx, ry);
        end
        return d[DW-1:0];
    endfunction

    // curve distance to coordinates, bottom level first
    function automatic wide_pair_t dist_to_xy(int unsigned ord,
                                              logic [DW-1:0] d_in);
        wide_pair_t  p;
        logic [63:0] t;
        logic [63:0] s;
        logic        rx;
        logic        ry;
        t = {32'd0, d_in} & low_bits(2 * ord);
        p = '0;
        for (int lvl = 0; lvl < int'(ord); lvl++) begin
            s  = 64'd1 << lvl;
            rx = t[1];
            ry = t[0] ^ rx;
            p  = quad_turn(s, p, rx, ry);
            p.x = p.x + (rx ? s : 64'd0);
            p.y = p.y + (ry ? s : 64'd0);
            t  = t >> 2;
        end
        return p;
    endfunction

    function automatic conv_result_t predict(int unsigned ord, logic cmd,
                                             logic [TW-1:0] data);
        conv_result_t r;
        wide_pair_t   p;
        r = '0;
        if (cmd == hcc_pkg::CMD_ENCODE) begin
            r.curve_d = xy_to_dist(ord, data[CW-1:0], data[2*CW-1:CW]);
        end else begin
            p   = dist_to_xy(ord, data[TW-1:2*CW]);
            r.x = p.x[CW-1:0];
            r.y = p.y[CW-1:0];
        end
        return r;
    endfunction

    function automatic void report_field(string name, logic [DW-1:0] want,
                                         logic [DW-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endfunction

    // result check first, then new prediction, then order update
    always @(posedge aclk) begin
        conv_result_t want;
        conv_result_t got;
        if (!aresetn) begin
            order_reg = hcc_pkg::GRID_ORDER_RST;
            conversion_q.delete();
            mismatches = 0;
            conv_checked <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (conversion_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result transaction with no conversion pending: %h",
                                 m_tdata);
                end else begin
                    want = conversion_q.pop_front();
                    report_field("out_x", {16'd0, want.x}, {16'd0, got.x});
                    report_field("out_y", {16'd0, want.y}, {16'd0, got.y});
                    report_field("out_dist", want.curve_d, got.curve_d);
                    conv_checked <= conv_checked + 1;
                end
            end
            if (s_tvalid && s_tready)
                conversion_q.insert(conversion_q.size(),
                                    predict(clip_order(order_reg), s_tuser, s_tdata));
            if (cfg_valid && cfg_ready)
                order_reg = cfg_data;
        end
        fail_count       <= mismatches;
        conv_outstanding <= conversion_q.size();
    end

endmodule

// ===== sim/hilbert_curve_converter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hilbert_curve_converter_unit_tb
// Drives encode and decode transactions through the converter at several grid
// orders, with random gaps and back-pressure, and reports the checker verdict.
// ----------------------------------------------------------------------------
module hilbert_curve_converter_unit_tb;

    localparam int CW = hcc_pkg::COORD_W;
    localparam int DW = hcc_pkg::DIST_W;
    localparam int OW = hcc_pkg::ORDER_W;
    localparam int TW = hcc_pkg::TDATA_W;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [OW-1:0] cfg_data  = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [TW-1:0] s_tdata   = '0;     // in_x, in_y, in_dist
    logic          s_tuser   = 1'b0;   // cmd
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [TW-1:0] m_tdata;            // out_x, out_y, out_dist

    int fail_count;
    int conv_outstanding;
    int conv_checked;

    bit idle_en    = 1'b1;
    int stall_left = 0;
    int n_encode   = 0;
    int n_decode   = 0;
    int n_writes   = 0;

    int phase_orders[12] = '{16, 31, 2, 0, 17, 9, 1, 12, 3, -1, 5, -1};

    hilbert_curve_converter_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hcc_scoreboard u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .conv_outstanding(conv_outstanding),
        .conv_checked    (conv_checked)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // receiver back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (aresetn && idle_en && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one input transaction, with an optional gap ahead of it
    task automatic send_conv(logic cmd, logic [CW-1:0] x, logic [CW-1:0] y,
                             logic [DW-1:0] d_in);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {d_in, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == hcc_pkg::CMD_ENCODE) n_encode++;
        else n_decode++;
    endtask

    // hold the sender until every pending result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (conv_outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_order(logic [OW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        n_writes++;
    endtask

    task automatic random_conv();
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [DW-1:0] d;
        x = CW'($urandom);
        y = CW'($urandom);
        d = DW'($urandom);
        // corner values now and then
        case ($urandom_range(0, 15))
            0: begin x = '0; y = '0; d = '0; end
            1: begin x = '1; y = '1; d = '1; end
            2: begin x = '1; y = '0; d = 32'h5555_5555; end
            default: ;
        endcase
        send_conv($urandom_range(0, 1) ? hcc_pkg::CMD_DECODE : hcc_pkg::CMD_ENCODE,
                  x, y, d);
    endtask

    initial begin
        int ord;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes at the reset order of 16, unused fields loaded with junk
        send_conv(hcc_pkg::CMD_ENCODE, 16'h0000, 16'h0000, 32'hffff_ffff);
        send_conv(hcc_pkg::CMD_ENCODE, 16'hffff, 16'hffff, 32'h1234_5678);
        send_conv(hcc_pkg::CMD_ENCODE, 16'hffff, 16'h0000, 32'h0);
        send_conv(hcc_pkg::CMD_ENCODE, 16'h0000, 16'hffff, 32'h0);
        send_conv(hcc_pkg::CMD_ENCODE, 16'h0001, 16'h0000, 32'h0);
        send_conv(hcc_pkg::CMD_ENCODE, 16'h8000, 16'h7fff, 32'h0);
        send_conv(hcc_pkg::CMD_DECODE, 16'hffff, 16'hffff, 32'h0000_0000);
        send_conv(hcc_pkg::CMD_DECODE, 16'h0, 16'h0, 32'hffff_ffff);
        send_conv(hcc_pkg::CMD_DECODE, 16'h0, 16'h0, 32'h0000_0003);
        send_conv(hcc_pkg::CMD_DECODE, 16'h0, 16'h0, 32'h5555_5555);
        send_conv(hcc_pkg::CMD_DECODE, 16'h0, 16'h0, 32'haaaa_aaaa);
        send_conv(hcc_pkg::CMD_DECODE, 16'h0, 16'h0, 32'h8000_0000);
        drain();

        // single-cell grid: everything collapses to zero
        write_order(5'd0);
        send_conv(hcc_pkg::CMD_ENCODE, 16'hffff, 16'hffff, 32'hffff_ffff);
        send_conv(hcc_pkg::CMD_DECODE, 16'hffff, 16'hffff, 32'hffff_ffff);
        drain();

        // order one: all four cells, bits above the grid set
        write_order(5'd1);
        for (int c = 0; c < 4; c++) begin
            send_conv(hcc_pkg::CMD_ENCODE, {15'h7fff, c[0]}, {15'h5555, c[1]}, 32'h0);
            send_conv(hcc_pkg::CMD_DECODE, 16'h0, 16'h0, {30'h3fff_fffc, c[1:0]});
        end
        drain();

        // order above the maximum saturates
        write_order(5'd31);
        send_conv(hcc_pkg::CMD_ENCODE, 16'hffff, 16'h0000, 32'h0);
        send_conv(hcc_pkg::CMD_DECODE, 16'h0, 16'h0, 32'hffff_ffff);
        drain();

        // random phases over a spread of orders
        foreach (phase_orders[p]) begin
            ord = (phase_orders[p] < 0) ? $urandom_range(0, 31) : phase_orders[p];
            write_order(ord[OW-1:0]);
            for (int i = 0; i < 150; i++) begin
                if (i % 50 == 0) idle_en = ($urandom_range(0, 3) != 0);
                random_conv();
            end
            drain();
        end

        idle_en = 1'b1;
        repeat (10) @(posedge aclk);
        $display("covered %0d encode and %0d decode conversions, %0d results checked",
                 n_encode, n_decode, conv_checked);
        $display("grid order written %0d times, saturation and single-cell included",
                 n_writes);
        if (fail_count == 0 && conv_outstanding == 0) begin
            $display("hilbert_curve_converter_unit verification clean");
        end else begin
            $display("hilbert_curve_converter_unit verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("timeout");
        $display("hilbert_curve_converter_unit verification failed");
        $finish;
    end

endmodule

// ===== hilbert_curve_converter_unit.f =====
src/hcc_pkg.sv
src/hcc_level.sv
src/hcc_datapath.sv
src/hilbert_curve_converter_unit.sv
src/hcc_checker.sv
sim/hcc_checker.sv
sim/hilbert_curve_converter_unit_tb.sv
